FILE: src/psts_pkg.sv
// shared types and constants of the polar scan to screen points block
// no dependencies; all other files but psts_queue refer to it by scoped names
package psts_pkg;

    localparam int STEPS_PER_TURN_DEF = 360;

    // field widths
    localparam int ANGLE_W   = 9;
    localparam int DIST_W    = 16;
    localparam int REFL_W    = 16;
    localparam int CFG_W     = 10;
    localparam int RAD_W     = CFG_W;
    localparam int PT_W      = 11;
    localparam int COLOR_W   = 16;
    localparam int TRIG_W    = 17;
    localparam int FRAC_W    = 15;
    localparam int CFG_IDX_W = 2;

    // distance / 5 by reciprocal: exact for every 16 bit distance
    localparam int              RQ_W    = 14;
    localparam int              DIV5_SH = 19;
    localparam int              DIV5_MW = 17;
    localparam logic [16:0]     DIV5_M  = 17'd104858;

    localparam logic [COLOR_W-1:0] COLOR_NO_RETURN = 16'hA000;
    localparam logic [COLOR_W-1:0] COLOR_OFFSET    = 16'h0AF0;
    localparam logic [COLOR_W-1:0] COLOR_ERASE     = 16'h0000;

    localparam logic [PT_W-1:0] PT_MAX = {PT_W{1'b1}};

    localparam logic [CFG_W-1:0] CENTER_X_RST   = 10'd400;
    localparam logic [CFG_W-1:0] CENTER_Y_RST   = 10'd200;
    localparam logic [CFG_W-1:0] MAX_RADIUS_RST = 10'd200;

    localparam int QUEUE_DEPTH = 4;

    // fixed point angle constants for the sine table
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] OCTANT_Q30  = 64'd1 << 29;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X   = 2'd0,
        CFG_CENTER_Y   = 2'd1,
        CFG_MAX_RADIUS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] center_x;
        logic [CFG_W-1:0] center_y;
        logic [CFG_W-1:0] max_radius;
    } t_cfg;

    typedef struct packed {
        logic [RAD_W-1:0]   radius;
        logic [COLOR_W-1:0] color;
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

FILE: src/psts_if.sv
// valid/ready channel interfaces for range samples and screen points
// depends on psts_pkg for the field widths
interface psts_sample_if;
    logic                            valid;
    logic                            ready;
    logic [psts_pkg::ANGLE_W-1:0]    angle_index;
    logic [psts_pkg::DIST_W-1:0]     distance;
    logic [psts_pkg::REFL_W-1:0]     reflectivity;

    modport source (output valid, output angle_index, output distance,
                    output reflectivity, input ready);
    modport sink   (input valid, input angle_index, input distance,
                    input reflectivity, output ready);
endinterface

interface psts_point_if;
    logic                            valid;
    logic                            ready;
    logic [psts_pkg::PT_W-1:0]       point_x;
    logic [psts_pkg::PT_W-1:0]       point_y;
    logic [psts_pkg::COLOR_W-1:0]    pixel_color;
    logic                            last;

    modport source (output valid, output point_x, output point_y,
                    output pixel_color, output last, input ready);
    modport sink   (input valid, input point_x, input point_y,
                    input pixel_color, input last, output ready);
endinterface

FILE: src/psts_front.sv
// front end: takes range samples, wraps the step index, scales the radius
// and picks the colour; depends on psts_pkg and psts_if
module psts_front #(
    parameter int STEPS_PER_TURN = psts_pkg::STEPS_PER_TURN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_hold,
    input  logic [psts_pkg::CFG_W-1:0]         i_max_radius,
    psts_sample_if.sink                        i_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [$clog2(STEPS_PER_TURN)-1:0]  o_k,
    output psts_pkg::t_job                     o_job
);

    localparam int KW = $clog2(STEPS_PER_TURN);
    localparam int AW = psts_pkg::ANGLE_W;
    localparam int SH = AW + KW;
    localparam int MW = AW + 2;
    localparam logic [63:0] M_ANG_L =
        ((64'd1 << SH) + 64'(STEPS_PER_TURN) - 64'd1) / 64'(STEPS_PER_TURN);
    localparam logic [MW-1:0] M_ANG   = MW'(M_ANG_L);
    localparam int            QPW     = AW + KW + 1;
    localparam logic [KW:0]   STEPS_C = (KW+1)'(STEPS_PER_TURN);
    localparam int            DPW     = psts_pkg::DIST_W + psts_pkg::DIV5_MW;

    logic                         w_s1_free;
    logic                         w_s2_free;
    logic                         w_accept;
    logic [AW+MW-1:0]             w_ang_prod;
    logic [AW-1:0]                w_ang_q;
    logic [DPW-1:0]               w_dist_prod;
    logic [psts_pkg::RQ_W-1:0]    w_dist_q;
    logic [psts_pkg::COLOR_W-1:0] w_color;
    logic [QPW-1:0]               w_qs_prod;
    logic [AW-1:0]                w_k_full;
    logic [psts_pkg::RAD_W-1:0]   w_radius;

    logic                         r_s1_valid;
    logic [AW-1:0]                r_s1_angle;
    logic [AW-1:0]                r_s1_q;
    logic [psts_pkg::RQ_W-1:0]    r_s1_rq;
    logic                         r_s1_zero;
    logic [psts_pkg::COLOR_W-1:0] r_s1_color;
    logic                         r_s2_valid;
    logic [KW-1:0]                r_s2_k;
    psts_pkg::t_job               r_s2_job;

    assign w_s2_free      = !r_s2_valid || i_ready;
    assign w_s1_free      = !r_s1_valid || w_s2_free;
    assign i_sample.ready = w_s1_free && !i_hold;
    assign w_accept       = i_sample.valid && i_sample.ready;

    // quotient of the step index by the turn length, reciprocal form
    assign w_ang_prod  = (AW+MW)'(i_sample.angle_index) * (AW+MW)'(M_ANG);
    assign w_ang_q     = AW'(w_ang_prod >> SH);
    assign w_dist_prod = DPW'(i_sample.distance) * DPW'(psts_pkg::DIV5_M);
    assign w_dist_q    = psts_pkg::RQ_W'(w_dist_prod >> psts_pkg::DIV5_SH);
    assign w_color     = (i_sample.reflectivity == '0) ? psts_pkg::COLOR_NO_RETURN :
                         i_sample.reflectivity + psts_pkg::COLOR_OFFSET;

    assign w_qs_prod = QPW'(r_s1_q) * QPW'(STEPS_C);
    assign w_k_full  = r_s1_angle - AW'(w_qs_prod);

    always_comb begin
        if (r_s1_zero) begin
            w_radius = i_max_radius;
        end else if (r_s1_rq > psts_pkg::RQ_W'(i_max_radius)) begin
            w_radius = i_max_radius;
        end else begin
            w_radius = psts_pkg::RAD_W'(r_s1_rq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= w_accept;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_angle <= i_sample.angle_index;
            r_s1_q     <= w_ang_q;
            r_s1_rq    <= w_dist_q;
            r_s1_zero  <= (i_sample.reflectivity == '0);
            r_s1_color <= w_color;
        end
        if (w_s2_free && r_s1_valid) begin
            r_s2_k          <= KW'(w_k_full);
            r_s2_job.radius <= w_radius;
            r_s2_job.color  <= r_s1_color;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_k     = r_s2_k;
    assign o_job   = r_s2_job;

endmodule

FILE: src/psts_queue.sv
// short first-in first-out queue between the front and back ends
// depends on nothing but its parameters
module psts_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (w_pop && !w_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: src/psts_back.sv
// back end: sine table, radius scaling, point placement, previous point
// store and the two-result output stage; depends on psts_pkg and psts_if
module psts_back #(
    parameter int STEPS_PER_TURN = psts_pkg::STEPS_PER_TURN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [psts_pkg::CFG_W-1:0]         i_center_x,
    input  logic [psts_pkg::CFG_W-1:0]         i_center_y,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [$clog2(STEPS_PER_TURN)-1:0]  i_k,
    input  psts_pkg::t_job                     i_job,
    output logic                               o_busy,
    psts_point_if.source                       o_point
);

    localparam int KW  = $clog2(STEPS_PER_TURN);
    localparam int TW  = psts_pkg::TRIG_W;
    localparam int FW  = psts_pkg::FRAC_W;
    localparam int PTW = psts_pkg::PT_W;
    localparam int PW  = psts_pkg::RAD_W + 1 + TW;
    localparam int MGW = PW - FW + 1;
    localparam logic [KW-1:0] CLR_LAST = KW'(STEPS_PER_TURN - 1);

    // cosine and sine of one step, Q1.15 with +1.0 kept as 32768
    function automatic logic [2*TW-1:0] f_trig(input int unsigned step);
        logic [63:0]          t_full;
        logic [63:0]          r;
        logic [63:0]          x;
        logic [63:0]          x2;
        logic [63:0]          p;
        logic [63:0]          sv;
        logic [63:0]          cv;
        logic [63:0]          sq;
        logic [63:0]          cq;
        logic [1:0]           quad;
        logic                 mirror;
        logic signed [TW-1:0] s;
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] sw;
        logic signed [TW-1:0] co;
        logic signed [TW-1:0] so;
        t_full = ({32'd0, 32'(step)} << 32) / STEPS_PER_TURN;
        quad   = t_full[31:30];
        r      = {34'd0, t_full[29:0]};
        mirror = (r > psts_pkg::OCTANT_Q30);
        if (mirror) begin
            r = psts_pkg::ONE_Q30 - r;
        end
        x  = (r * psts_pkg::PI_HALF_Q30) >> 30;
        x2 = (x * x) >> 30;
        p  = psts_pkg::ONE_Q30 - x2 / 72;
        p  = psts_pkg::ONE_Q30 - ((x2 * p) >> 30) / 42;
        p  = psts_pkg::ONE_Q30 - ((x2 * p) >> 30) / 20;
        p  = psts_pkg::ONE_Q30 - ((x2 * p) >> 30) / 6;
        sv = (x * p) >> 30;
        p  = psts_pkg::ONE_Q30 - x2 / 56;
        p  = psts_pkg::ONE_Q30 - ((x2 * p) >> 30) / 30;
        p  = psts_pkg::ONE_Q30 - ((x2 * p) >> 30) / 12;
        cv = psts_pkg::ONE_Q30 - ((x2 * p) >> 30) / 2;
        sq = (sv + (64'd1 << 14)) >> 15;
        cq = (cv + (64'd1 << 14)) >> 15;
        s  = TW'(sq);
        c  = TW'(cq);
        if (mirror) begin
            sw = s;
            s  = c;
            c  = sw;
        end
        case (quad)
            2'd0: begin
                co = c;
                so = s;
            end
            2'd1: begin
                co = -s;
                so = c;
            end
            2'd2: begin
                co = -c;
                so = -s;
            end
            default: begin
                co = s;
                so = -c;
            end
        endcase
        return {co, so};
    endfunction

    // center plus scaled trig, floored and clamped to the screen range
    function automatic logic [PTW-1:0] f_place(input logic [psts_pkg::CFG_W-1:0] center,
                                               input logic signed [PW-1:0] prod);
        logic signed [PW:0] v;
        logic [MGW-1:0]     mag;
        v   = (PW+1)'($signed({1'b0, center, FW'(0)})) + (PW+1)'(prod);
        mag = v[PW:FW];
        if (v[PW]) begin
            return '0;
        end else if (mag > MGW'(psts_pkg::PT_MAX)) begin
            return psts_pkg::PT_MAX;
        end else begin
            return PTW'(mag);
        end
    endfunction

    logic [2*TW-1:0] w_rom [STEPS_PER_TURN];

    for (genvar g = 0; g < STEPS_PER_TURN; g++) begin : g_rom
        localparam logic [2*TW-1:0] ENTRY = f_trig(g);
        assign w_rom[g] = ENTRY;
    end

    logic [2*PTW-1:0]             r_mem [STEPS_PER_TURN];
    logic [2*PTW-1:0]             r_rd_data;
    logic                         r_byp;
    logic [2*PTW-1:0]             r_byp_data;

    logic                         r_clear;
    logic [KW-1:0]                r_clr_addr;

    logic                         r_b1_valid;
    logic [KW-1:0]                r_b1_k;
    logic [psts_pkg::RAD_W-1:0]   r_b1_radius;
    logic [psts_pkg::COLOR_W-1:0] r_b1_color;
    logic [2*TW-1:0]              r_b1_trig;

    logic                         r_b2_valid;
    logic [KW-1:0]                r_b2_k;
    logic [psts_pkg::COLOR_W-1:0] r_b2_color;
    logic [2*PTW-1:0]             r_b2_prev;
    logic signed [PW-1:0]         r_b2_xprod;
    logic signed [PW-1:0]         r_b2_yprod;

    logic                         r_b3_valid;
    logic                         r_phase;
    logic [2*PTW-1:0]             r_b3_prev;
    logic [PTW-1:0]               r_b3_px;
    logic [PTW-1:0]               r_b3_py;
    logic [psts_pkg::COLOR_W-1:0] r_b3_color;

    logic                         w_out_take;
    logic                         w_b3_free;
    logic                         w_b2_move;
    logic                         w_b2_free;
    logic                         w_b1_move;
    logic                         w_b1_free;
    logic                         w_hazard;
    logic                         w_pop;
    logic signed [TW-1:0]         w_b1_cos;
    logic signed [TW-1:0]         w_b1_sin;
    logic [2*PTW-1:0]             w_b1_prev;
    logic [PTW-1:0]               w_px;
    logic [PTW-1:0]               w_py;
    logic                         w_wr_en;
    logic [KW-1:0]                w_wr_addr;
    logic [2*PTW-1:0]             w_wr_data;

    assign w_out_take = r_b3_valid && o_point.ready;
    assign w_b3_free  = !r_b3_valid || (w_out_take && r_phase);
    assign w_b2_move  = r_b2_valid && w_b3_free;
    assign w_b2_free  = !r_b2_valid || w_b2_move;
    assign w_b1_move  = r_b1_valid && w_b2_free;
    assign w_b1_free  = !r_b1_valid || w_b1_move;

    // a step still in flight holds back a later sample of the same step until
    // its store write is due in the same cycle as the read (then bypassed)
    assign w_hazard = (r_b1_valid && (r_b1_k == i_k)) ||
                      (r_b2_valid && (r_b2_k == i_k) && !w_b2_move);
    assign o_ready  = w_b1_free && !r_clear && !w_hazard;
    assign w_pop    = i_valid && o_ready;
    assign o_busy   = r_clear;

    assign w_b1_cos  = r_b1_trig[2*TW-1:TW];
    assign w_b1_sin  = r_b1_trig[TW-1:0];
    assign w_b1_prev = r_byp ? r_byp_data : r_rd_data;

    assign w_px = f_place(i_center_x, r_b2_xprod);
    assign w_py = f_place(i_center_y, r_b2_yprod);

    assign w_wr_en   = r_clear || w_b2_move;
    assign w_wr_addr = r_clear ? r_clr_addr : r_b2_k;
    assign w_wr_data = r_clear ? '0 : {w_px, w_py};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else begin
            if (r_clear) begin
                r_clr_addr <= KW'(r_clr_addr + 1'b1);
                if (r_clr_addr == CLR_LAST) begin
                    r_clear <= 1'b0;
                end
            end
            if (w_b1_free) begin
                r_b1_valid <= w_pop;
            end
            if (w_b2_free) begin
                r_b2_valid <= r_b1_valid;
            end
            if (w_b2_move) begin
                r_b3_valid <= 1'b1;
                r_phase    <= 1'b0;
            end else if (w_out_take) begin
                if (r_phase) begin
                    r_b3_valid <= 1'b0;
                end else begin
                    r_phase <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_b1_k      <= i_k;
            r_b1_radius <= i_job.radius;
            r_b1_color  <= i_job.color;
            r_b1_trig   <= w_rom[i_k];
            r_byp       <= w_wr_en && (w_wr_addr == i_k);
            r_byp_data  <= w_wr_data;
        end
        if (w_b1_move) begin
            r_b2_k     <= r_b1_k;
            r_b2_color <= r_b1_color;
            r_b2_prev  <= w_b1_prev;
            r_b2_xprod <= $signed({1'b0, r_b1_radius}) * w_b1_cos;
            r_b2_yprod <= $signed({1'b0, r_b1_radius}) * w_b1_sin;
        end
        if (w_b2_move) begin
            r_b3_prev  <= r_b2_prev;
            r_b3_px    <= w_px;
            r_b3_py    <= w_py;
            r_b3_color <= r_b2_color;
        end
    end

    // previous point store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd_data <= r_mem[i_k];
        end
    end

    assign o_point.valid       = r_b3_valid;
    assign o_point.last        = r_phase;
    assign o_point.point_x     = r_phase ? r_b3_px : r_b3_prev[2*PTW-1:PTW];
    assign o_point.point_y     = r_phase ? r_b3_py : r_b3_prev[PTW-1:0];
    assign o_point.pixel_color = r_phase ? r_b3_color : psts_pkg::COLOR_ERASE;

`ifndef SYNTHESIS
    a_point_follows_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && !r_phase) |=> (r_b3_valid && r_phase))
        else $error("erase result not followed by its new point");

    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clear |-> !w_pop)
        else $error("sample taken during the store clearing pass");

    a_clear_runs_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clear && (r_clr_addr != CLR_LAST)) |=> r_clear)
        else $error("clearing pass ended early");
`endif

endmodule

FILE: src/polar_scan_to_screen_points.sv
// channel    dir  handshake      payload
// i_sample   in   valid/ready    angle_index, distance, reflectivity
// o_point    out  valid/ready    point_x, point_y, pixel_color, last
// i_cfg_*    in   write enable   i_cfg_idx, i_cfg_wdata (center_x, center_y, max_radius)
//
// two results per sample (erase at the old point, then the new point), so the
// output port, one result at a time, sets the sustained sample rate
// a sample passes front stages s1, s2, the queue and back stages b1, b2, b3 to the output
// after reset a clearing pass zeroes all STEPS_PER_TURN entries (360 by default) of
// the previous point store; i_sample.ready stays low until it is done
// a 4-entry queue parts front and back; a sample for the same step as one
// still in flight waits until the store write for that step is due
//
// top level: configuration registers, front end, queue and back end
// depends on psts_pkg, psts_if, psts_front, psts_queue and psts_back
module polar_scan_to_screen_points #(
    parameter int STEPS_PER_TURN = psts_pkg::STEPS_PER_TURN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [psts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [psts_pkg::CFG_W-1:0]         i_cfg_wdata,
    psts_sample_if.sink                        i_sample,
    psts_point_if.source                       o_point
);

    localparam int KW = $clog2(STEPS_PER_TURN);
    localparam int QW = KW + psts_pkg::JOB_W;

    psts_pkg::t_cfg  r_cfg;

    logic            w_busy;
    logic            w_f_valid;
    logic            w_f_ready;
    logic [KW-1:0]   w_f_k;
    psts_pkg::t_job  w_f_job;
    logic            w_q_valid;
    logic            w_q_ready;
    logic [QW-1:0]   w_q_data;
    psts_pkg::t_job  w_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x   <= psts_pkg::CENTER_X_RST;
            r_cfg.center_y   <= psts_pkg::CENTER_Y_RST;
            r_cfg.max_radius <= psts_pkg::MAX_RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (psts_pkg::t_cfg_idx'(i_cfg_idx))
                psts_pkg::CFG_CENTER_X:   r_cfg.center_x   <= i_cfg_wdata;
                psts_pkg::CFG_CENTER_Y:   r_cfg.center_y   <= i_cfg_wdata;
                psts_pkg::CFG_MAX_RADIUS: r_cfg.max_radius <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    psts_front #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (w_busy),
        .i_max_radius (r_cfg.max_radius),
        .i_sample     (i_sample),
        .o_valid      (w_f_valid),
        .i_ready      (w_f_ready),
        .o_k          (w_f_k),
        .o_job        (w_f_job)
    );

    psts_queue #(
        .WIDTH (QW),
        .DEPTH (psts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  ({w_f_k, w_f_job}),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_data)
    );

    assign w_q_job = w_q_data[psts_pkg::JOB_W-1:0];

    psts_back #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_center_x (r_cfg.center_x),
        .i_center_y (r_cfg.center_y),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_k        (w_q_data[QW-1:psts_pkg::JOB_W]),
        .i_job      (w_q_job),
        .o_busy     (w_busy),
        .o_point    (o_point)
    );

endmodule

FILE: tb/sv/psts_tb_pkg.sv
`timescale 1ns / 1ps
// point tracker for the polar scan testbench: predicts erase and draw points per sample
// and checks the block's points in order; depends on psts_pkg for widths and register codes
package psts_tb_pkg;

    localparam int STEPS = psts_pkg::STEPS_PER_TURN_DEF;

    typedef struct packed {
        logic [psts_pkg::PT_W-1:0]    x;
        logic [psts_pkg::PT_W-1:0]    y;
        logic [psts_pkg::COLOR_W-1:0] color;
        logic                         last;
    } t_screen_point;

    class screen_point_tracker;
        logic [psts_pkg::CFG_W-1:0] center_x;
        logic [psts_pkg::CFG_W-1:0] center_y;
        logic [psts_pkg::CFG_W-1:0] max_radius;
        logic [psts_pkg::PT_W-1:0]  drawn_x[STEPS];
        logic [psts_pkg::PT_W-1:0]  drawn_y[STEPS];
        int                         cos_q15[STEPS];
        int                         sin_q15[STEPS];
        t_screen_point              pending_points[$];
        int                         n_samples;
        int                         n_points;
        int                         n_errors;

        function new();
            longint unsigned one, turn, r, x, x2, p, sv, cv;
            int sq, cq, tmp;
            bit mirror;
            logic [1:0] quad;
            center_x   = psts_pkg::CENTER_X_RST;
            center_y   = psts_pkg::CENTER_Y_RST;
            max_radius = psts_pkg::MAX_RADIUS_RST;
            foreach (drawn_x[i]) begin
                drawn_x[i] = '0;
                drawn_y[i] = '0;
            end
            n_samples = 0;
            n_points  = 0;
            n_errors  = 0;
            one = 64'd1 << 30;
            // Q1.15 table built from the Q2.30 phase, octant folded
            for (int k = 0; k < STEPS; k++) begin
                turn = k;
                turn = (turn << 32) / STEPS;
                quad = turn[31:30];
                r = turn[29:0];
                mirror = (r > (one >> 1));
                if (mirror)
                    r = one - r;
                x  = (r * 64'd1686629713) >> 30;
                x2 = (x * x) >> 30;
                p  = one - x2 / 72;
                p  = one - ((x2 * p) >> 30) / 42;
                p  = one - ((x2 * p) >> 30) / 20;
                p  = one - ((x2 * p) >> 30) / 6;
                sv = (x * p) >> 30;
                p  = one - x2 / 56;
                p  = one - ((x2 * p) >> 30) / 30;
                p  = one - ((x2 * p) >> 30) / 12;
                cv = one - ((x2 * p) >> 30) / 2;
                sq = int'((sv + 64'd16384) >> 15);
                cq = int'((cv + 64'd16384) >> 15);
                if (mirror) begin
                    tmp = sq;
                    sq  = cq;
                    cq  = tmp;
                end
                // odd quadrant: quarter turn; upper half: negate both
                if (quad[0]) begin
                    tmp = cq;
                    cq  = -sq;
                    sq  = tmp;
                end
                if (quad[1]) begin
                    cq = -cq;
                    sq = -sq;
                end
                cos_q15[k] = cq;
                sin_q15[k] = sq;
            end
        endfunction

        function void write_register(psts_pkg::t_cfg_idx idx, logic [psts_pkg::CFG_W-1:0] v);
            case (idx)
                psts_pkg::CFG_CENTER_X:   center_x   = v;
                psts_pkg::CFG_CENTER_Y:   center_y   = v;
                psts_pkg::CFG_MAX_RADIUS: max_radius = v;
                default: ;
            endcase
        endfunction

        function logic [psts_pkg::PT_W-1:0] place(int unsigned center, int unsigned radius,
                                                  int trig);
            longint acc;
            acc = (longint'(center) << 15) + longint'(radius) * longint'(trig);
            if (acc < 0)
                return '0;
            acc = acc >>> 15;
            if (acc > 2047)
                return psts_pkg::PT_MAX;
            return acc[psts_pkg::PT_W-1:0];
        endfunction

        function void note_sample(logic [psts_pkg::ANGLE_W-1:0] angle,
                                  logic [psts_pkg::DIST_W-1:0] dist_val,
                                  logic [psts_pkg::REFL_W-1:0] refl);
            int unsigned k, radius;
            logic [psts_pkg::COLOR_W-1:0] color;
            t_screen_point erase, drawn;
            k = angle % STEPS;
            radius = dist_val / 5;
            if (refl == '0) begin
                color  = psts_pkg::COLOR_NO_RETURN;
                radius = max_radius;
            end else begin
                color = refl + psts_pkg::COLOR_OFFSET;
            end
            if (radius > max_radius)
                radius = max_radius;
            erase.x     = drawn_x[k];
            erase.y     = drawn_y[k];
            erase.color = psts_pkg::COLOR_ERASE;
            erase.last  = 1'b0;
            drawn.x     = place(center_x, radius, cos_q15[k]);
            drawn.y     = place(center_y, radius, sin_q15[k]);
            drawn.color = color;
            drawn.last  = 1'b1;
            pending_points.push_back(erase);
            pending_points.push_back(drawn);
            drawn_x[k] = drawn.x;
            drawn_y[k] = drawn.y;
            n_samples++;
        endfunction

        function void check_point(t_screen_point got);
            t_screen_point want;
            n_points++;
            if (pending_points.size() == 0) begin
                n_errors++;
                $display("%0t: expected no point, got x=%0d y=%0d color=%h last=%b", $time,
                         got.x, got.y, got.color, got.last);
                return;
            end
            want = pending_points.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                got.last !== want.last) begin
                n_errors++;
                $display("%0t: expected x=%0d y=%0d color=%h last=%b,", $time,
                         want.x, want.y, want.color, want.last);
                $display("    got x=%0d y=%0d color=%h last=%b",
                         got.x, got.y, got.color, got.last);
            end
        endfunction
    endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, register writes and range sample / screen point channels
// depends on psts_pkg, psts_if, psts_tb_pkg and polar_scan_to_screen_points
module tb_top;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RANDOM_PER_SET  = 110;
    localparam int N_DIRECTED      = 24;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         cfg_we;
    psts_pkg::t_cfg_idx           cfg_idx;
    logic [psts_pkg::CFG_W-1:0]   cfg_wdata;

    psts_sample_if sample_ch();
    psts_point_if  point_ch();

    polar_scan_to_screen_points DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_sample    (sample_ch),
        .o_point     (point_ch)
    );

    psts_tb_pkg::screen_point_tracker tracker = new();

    int cycle_count = 0;
    int n_settings  = 1;
    bit source_burst = 1'b0;
    bit sink_burst   = 1'b0;
    bit hold_off_req = 1'b0;
    int last_angle   = 0;

    // axes, diagonals, colour wrap, radius clamp, aliased steps, repeats of one step
    int directed_samples[N_DIRECTED][3] = '{
        '{0,   500,   16'h0064}, '{90,  1000,  16'h0001}, '{180, 1004,  16'hFFFF},
        '{270, 1005,  16'hF510}, '{45,  65535, 16'h0000}, '{359, 0,     16'h0001},
        '{360, 700,   16'h1234}, '{0,   250,   16'h4321}, '{511, 65535, 16'hFFFF},
        '{151, 3,     16'h8000}, '{1,   20000, 16'h0AF0}, '{89,  999,   16'h00FF},
        '{91,  998,   16'h7FFF}, '{179, 600,   16'h0000}, '{181, 601,   16'hA510},
        '{269, 1000,  16'h5555}, '{271, 1000,  16'hAAAA}, '{135, 2000,  16'h0000},
        '{225, 65534, 16'h0001}, '{315, 1000,  16'hFFFF}, '{270, 4,     16'h0002},
        '{10,  800,   16'h0100}, '{370, 900,   16'h0200}, '{10,  5,     16'h0000}
    };

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles, %0d points still pending", $time,
                     CYCLE_LIMIT, tracker.pending_points.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input logic [psts_pkg::ANGLE_W-1:0] angle,
                               input logic [psts_pkg::DIST_W-1:0] dist_val,
                               input logic [psts_pkg::REFL_W-1:0] refl);
        int gap;
        gap = source_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.angle_index  <= angle;
        sample_ch.distance     <= dist_val;
        sample_ch.reflectivity <= refl;
        do @(posedge i_clk); while (!sample_ch.ready);
        tracker.note_sample(angle, dist_val, refl);
        last_angle = angle;
        if ($urandom_range(0, 39) == 0)
            source_burst = !source_burst;
    endtask

    task automatic send_random_samples(input int count);
        int sel, angle, dist_val, refl, span;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                angle = $urandom_range(0, psts_tb_pkg::STEPS - 1);
            else if (sel == 7)
                angle = $urandom_range(psts_tb_pkg::STEPS, 511);
            else if (sel == 8)
                angle = last_angle;
            else
                angle = (last_angle < 152) ? last_angle + psts_tb_pkg::STEPS :
                        last_angle % psts_tb_pkg::STEPS;
            sel  = $urandom_range(0, 7);
            span = tracker.max_radius * 5;
            if (sel < 4)
                dist_val = $urandom_range(0, 65535);
            else if (sel < 7)
                dist_val = $urandom_range(0, span + 9);
            else
                dist_val = span + $urandom_range(0, 5);
            if (dist_val > 65535)
                dist_val = 65535;
            sel = $urandom_range(0, 7);
            if (sel == 0)
                refl = 0;
            else if (sel == 1)
                refl = $urandom_range(16'hF500, 16'hFFFF);
            else
                refl = $urandom_range(1, 65535);
            send_sample(psts_pkg::ANGLE_W'(angle), psts_pkg::DIST_W'(dist_val),
                        psts_pkg::REFL_W'(refl));
        end
    endtask

    // sender stops and waits until every predicted point has been taken
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_points.size() != 0);
    endtask

    task automatic program_config(input logic [psts_pkg::CFG_W-1:0] cx,
                                  input logic [psts_pkg::CFG_W-1:0] cy,
                                  input logic [psts_pkg::CFG_W-1:0] mr);
        cfg_we    <= 1'b1;
        cfg_idx   <= psts_pkg::CFG_CENTER_X;
        cfg_wdata <= cx;
        @(posedge i_clk);
        tracker.write_register(psts_pkg::CFG_CENTER_X, cx);
        cfg_idx   <= psts_pkg::CFG_CENTER_Y;
        cfg_wdata <= cy;
        @(posedge i_clk);
        tracker.write_register(psts_pkg::CFG_CENTER_Y, cy);
        cfg_idx   <= psts_pkg::CFG_MAX_RADIUS;
        cfg_wdata <= mr;
        @(posedge i_clk);
        tracker.write_register(psts_pkg::CFG_MAX_RADIUS, mr);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // point sink: random stalls, one long hold-off on request
    initial begin : point_sink
        int stall;
        psts_tb_pkg::t_screen_point got;
        point_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                point_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            point_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!point_ch.valid);
            got.x     = point_ch.point_x;
            got.y     = point_ch.point_y;
            got.color = point_ch.pixel_color;
            got.last  = point_ch.last;
            tracker.check_point(got);
            if ($urandom_range(0, 49) == 0)
                sink_burst = !sink_burst;
        end
    end

    initial begin : stimulus
        int cx, cy, mr;
        i_rst_n                <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= psts_pkg::CFG_CENTER_X;
        cfg_wdata              <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.angle_index  <= '0;
        sample_ch.distance     <= '0;
        sample_ch.reflectivity <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: directed corners then random
        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(psts_pkg::ANGLE_W'(directed_samples[i][0]),
                        psts_pkg::DIST_W'(directed_samples[i][1]),
                        psts_pkg::REFL_W'(directed_samples[i][2]));
        send_random_samples(RANDOM_PER_SET - N_DIRECTED);
        wait_drained();

        for (int set_no = 0; set_no < 5; set_no++) begin
            case (set_no)
                0: begin cx = 0;    cy = 0;    mr = 1023; end
                1: begin cx = 1023; cy = 1023; mr = 1023; end
                2: begin cx = 512;  cy = 300;  mr = 0;    end
                default: begin
                    cx = $urandom_range(0, 1023);
                    cy = $urandom_range(0, 1023);
                    mr = $urandom_range(0, 1023);
                end
            endcase
            program_config(psts_pkg::CFG_W'(cx), psts_pkg::CFG_W'(cy),
                           psts_pkg::CFG_W'(mr));
            if (set_no == 1) begin
                // output held off while samples arrive back to back
                source_burst = 1'b1;
                hold_off_req = 1'b1;
            end
            send_random_samples(RANDOM_PER_SET);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d samples under %0d register settings, %0d points checked",
                 tracker.n_samples, n_settings, tracker.n_points);
        $display("incl. zero and wrapping reflectivity, radius clamp, aliased steps, long output stall");
        if (tracker.n_errors == 0 && tracker.pending_points.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
